// ===== rtl/core/m3i_pkg.sv =====
`default_nettype none
package m3i_pkg;

    localparam int unsigned ELEMENT_BITS_DEF = 16;
    localparam int unsigned INV_SHIFT        = 28;
    localparam int unsigned Q_BITS           = 32;
    localparam int unsigned DET_BITS         = 50;
    localparam int unsigned FRONT_STAGES     = 8;
    localparam int unsigned DIV_STAGES       = Q_BITS + 1;

    // Operand indexes of each 2x2 cofactor: adj = m[a] * m[b] - m[c] * m[d].
    localparam int unsigned COF_A [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int unsigned COF_B [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int unsigned COF_C [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int unsigned COF_D [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

    // Adjugate entries that pair with the first row in the determinant expansion.
    localparam int unsigned DET_COF [3] = '{0, 3, 6};

    typedef struct packed {
        logic en;
    } t_ctl;

endpackage
`default_nettype wire

// ===== rtl/core/m3i_front.sv =====
`default_nettype none
module m3i_front #(
    parameter int unsigned E  = m3i_pkg::ELEMENT_BITS_DEF,
    parameter int unsigned RW = (2 * E + 1) + (3 * E + 2) + 30
) (
    input  wire                   i_clk,
    input  wire m3i_pkg::t_ctl    i_ctl,
    input  wire logic signed [E-1:0] i_a [9],
    output logic [RW-1:0]         o_num [9],
    output logic [RW-1:0]         o_den,
    output logic                  o_neg [9],
    output logic                  o_zero,
    output logic signed [m3i_pkg::DET_BITS-1:0] o_det
);
    localparam int unsigned CW = 2 * E + 1;
    localparam int unsigned DW = 3 * E + 2;
    localparam int unsigned XW = DW + m3i_pkg::DET_BITS + 1;
    localparam logic signed [XW-1:0] DMAX = (XW'(1) <<< (m3i_pkg::DET_BITS - 1)) - XW'(1);
    localparam logic signed [XW-1:0] DMIN = -(XW'(1) <<< (m3i_pkg::DET_BITS - 1));

    logic signed [E-1:0]    r_m [9];
    logic signed [2*E-1:0]  r_pa [9];
    logic signed [2*E-1:0]  r_pb [9];
    logic signed [E-1:0]    r_row2 [3];
    logic signed [E-1:0]    r_row3 [3];
    logic signed [CW-1:0]   r_adj [4][9];
    logic signed [2*E+1:0]  r_plo [3];
    logic signed [2*E+1:0]  r_phi [3];
    logic signed [DW-1:0]   r_t [3];
    logic signed [DW-1:0]   r_det;
    logic [DW-1:0]          r_dmag;
    logic                   r_dneg;
    logic                   r_zero7;
    logic signed [m3i_pkg::DET_BITS-1:0] r_detf7;
    logic [CW-1:0]          r_amag [9];
    logic                   r_aneg [9];
    logic [RW-1:0]          r_num [9];
    logic [RW-1:0]          r_den;
    logic                   r_neg [9];
    logic                   r_zero;
    logic signed [m3i_pkg::DET_BITS-1:0] r_detf;
    logic signed [XW-1:0]   n_dx;

    assign n_dx = XW'(r_det);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            for (int i = 0; i < 9; i++) begin
                r_m[i]  <= i_a[i];
                r_pa[i] <= r_m[m3i_pkg::COF_A[i]] * r_m[m3i_pkg::COF_B[i]];
                r_pb[i] <= r_m[m3i_pkg::COF_C[i]] * r_m[m3i_pkg::COF_D[i]];
                r_adj[0][i] <= CW'(r_pa[i]) - CW'(r_pb[i]);
                r_adj[1][i] <= r_adj[0][i];
                r_adj[2][i] <= r_adj[1][i];
                r_adj[3][i] <= r_adj[2][i];
                r_aneg[i] <= r_adj[3][i][CW-1];
                r_amag[i] <= r_adj[3][i][CW-1] ? (~r_adj[3][i] + CW'(1)) : r_adj[3][i];
                r_num[i]  <= (RW'(r_amag[i]) << (m3i_pkg::INV_SHIFT + 1)) + RW'(r_dmag);
                r_neg[i]  <= r_aneg[i] ^ r_dneg;
            end
            for (int j = 0; j < 3; j++) begin
                r_row2[j] <= r_m[j];
                r_row3[j] <= r_row2[j];
                // The cofactor is split into an unsigned low half and a signed high half.
                r_plo[j] <= r_row3[j] * $signed({1'b0, r_adj[0][m3i_pkg::DET_COF[j]][E-1:0]});
                r_phi[j] <= r_row3[j] * $signed(r_adj[0][m3i_pkg::DET_COF[j]][CW-1:E]);
                r_t[j]   <= (DW'(r_phi[j]) <<< E) + DW'(r_plo[j]);
            end
            r_det   <= r_t[0] + r_t[1] + r_t[2];
            r_dneg  <= r_det[DW-1];
            r_dmag  <= r_det[DW-1] ? (~r_det + DW'(1)) : r_det;
            r_zero7 <= (r_det == '0);
            if (n_dx > DMAX) begin
                r_detf7 <= DMAX[m3i_pkg::DET_BITS-1:0];
            end else if (n_dx < DMIN) begin
                r_detf7 <= DMIN[m3i_pkg::DET_BITS-1:0];
            end else begin
                r_detf7 <= n_dx[m3i_pkg::DET_BITS-1:0];
            end
            r_den  <= RW'(r_dmag) << 1;
            r_zero <= r_zero7;
            r_detf <= r_detf7;
        end
    end

    assign o_num  = r_num;
    assign o_den  = r_den;
    assign o_neg  = r_neg;
    assign o_zero = r_zero;
    assign o_det  = r_detf;

endmodule
`default_nettype wire

// ===== rtl/core/m3i_div.sv =====
`default_nettype none
module m3i_div #(
    parameter int unsigned RW = 80
) (
    input  wire                i_clk,
    input  wire m3i_pkg::t_ctl i_ctl,
    input  wire logic [RW-1:0] i_num,
    input  wire logic [RW-1:0] i_den,
    input  wire logic          i_neg,
    input  wire logic          i_zero,
    output logic [m3i_pkg::Q_BITS-1:0] o_q
);
    localparam int unsigned QB = m3i_pkg::Q_BITS;

    logic [RW-1:0] r_rem [QB];
    logic [RW-1:0] r_den [QB];
    logic [QB-1:0] r_q   [QB];
    logic          r_neg [QB];
    logic          r_zero [QB];
    logic          r_ovf [QB];
    logic [QB-1:0] r_out;

    for (genvar j = 0; j < QB; j++) begin : g_stage
        localparam int unsigned K = QB - 1 - j;
        logic [RW-1:0] w_rem;
        logic [RW-1:0] w_den;
        logic [RW-1:0] w_sh;
        logic [QB-1:0] w_qp;
        logic          w_negp;
        logic          w_zerop;
        logic          w_ovfp;
        if (j == 0) begin : g_first
            assign w_rem   = i_num;
            assign w_den   = i_den;
            assign w_qp    = '0;
            assign w_negp  = i_neg;
            assign w_zerop = i_zero;
            // A quotient of 2^32 or more can only saturate.
            assign w_ovfp  = (i_num >= (i_den << QB));
        end else begin : g_next
            assign w_rem   = r_rem[j-1];
            assign w_den   = r_den[j-1];
            assign w_qp    = r_q[j-1];
            assign w_negp  = r_neg[j-1];
            assign w_zerop = r_zero[j-1];
            assign w_ovfp  = r_ovf[j-1];
        end
        assign w_sh = w_den << K;

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_den[j] <= w_den;
                if (w_rem >= w_sh) begin
                    r_rem[j] <= w_rem - w_sh;
                end else begin
                    r_rem[j] <= w_rem;
                end
                r_q[j]    <= w_qp | ((w_rem >= w_sh) ? (QB'(1) << K) : '0);
                r_neg[j]  <= w_negp;
                r_zero[j] <= w_zerop;
                r_ovf[j]  <= w_ovfp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            if (r_zero[QB-1]) begin
                r_out <= '0;
            end else if (!r_neg[QB-1]) begin
                r_out <= (r_ovf[QB-1] || r_q[QB-1][QB-1]) ? {1'b0, {(QB-1){1'b1}}}
                                                          : r_q[QB-1];
            end else begin
                r_out <= (r_ovf[QB-1] || r_q[QB-1] > {1'b1, {(QB-1){1'b0}}})
                         ? {1'b1, {(QB-1){1'b0}}} : (~r_q[QB-1] + QB'(1));
            end
        end
    end

    assign o_q = r_out;

endmodule
`default_nettype wire

// ===== rtl/core/mat3_inverse.sv =====
`default_nettype none
// Inverse of a 3x3 signed Q4.12 matrix as adjugate over determinant, returned as
// nine saturated, round-to-nearest Q16.16 elements with the exact Q14.36 determinant
// and a singular flag (all elements zero when the determinant is zero). The block
// takes one matrix every cycle unless the output stalls; each item passes through eight
// stages of products, cofactors and determinant, then 32 restoring divider stages
// (one quotient bit each) and a saturation stage. A stall at the output holds the
// whole pipeline, so no item is lost or repeated.
module mat3_inverse #(
    parameter int unsigned ELEMENT_BITS = m3i_pkg::ELEMENT_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire logic signed [ELEMENT_BITS-1:0] i_a00,
    input  wire logic signed [ELEMENT_BITS-1:0] i_a01,
    input  wire logic signed [ELEMENT_BITS-1:0] i_a02,
    input  wire logic signed [ELEMENT_BITS-1:0] i_a10,
    input  wire logic signed [ELEMENT_BITS-1:0] i_a11,
    input  wire logic signed [ELEMENT_BITS-1:0] i_a12,
    input  wire logic signed [ELEMENT_BITS-1:0] i_a20,
    input  wire logic signed [ELEMENT_BITS-1:0] i_a21,
    input  wire logic signed [ELEMENT_BITS-1:0] i_a22,
    output logic      o_valid,
    input  wire logic i_stall,
    output logic signed [31:0] o_inv_00,
    output logic signed [31:0] o_inv_01,
    output logic signed [31:0] o_inv_02,
    output logic signed [31:0] o_inv_10,
    output logic signed [31:0] o_inv_11,
    output logic signed [31:0] o_inv_12,
    output logic signed [31:0] o_inv_20,
    output logic signed [31:0] o_inv_21,
    output logic signed [31:0] o_inv_22,
    output logic signed [m3i_pkg::DET_BITS-1:0] o_determinant,
    output logic      o_singular
);
    localparam int unsigned RW  = (2 * ELEMENT_BITS + 1) + (3 * ELEMENT_BITS + 2) + 30;
    localparam int unsigned LAT = m3i_pkg::FRONT_STAGES + m3i_pkg::DIV_STAGES;
    localparam int unsigned DD  = m3i_pkg::DIV_STAGES;

    m3i_pkg::t_ctl n_ctl;
    logic [LAT-1:0] r_vld;
    logic signed [ELEMENT_BITS-1:0] w_a [9];
    logic [RW-1:0] w_num [9];
    logic [RW-1:0] w_den;
    logic          w_neg [9];
    logic          w_zero;
    logic signed [m3i_pkg::DET_BITS-1:0] w_det;
    logic [m3i_pkg::Q_BITS-1:0] w_q [9];
    logic signed [m3i_pkg::DET_BITS-1:0] r_detd [DD];
    logic          r_sngd [DD];

    assign o_stall  = r_vld[LAT-1] && i_stall;
    assign n_ctl.en = !o_stall;

    assign w_a = '{i_a00, i_a01, i_a02, i_a10, i_a11, i_a12, i_a20, i_a21, i_a22};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (n_ctl.en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    m3i_front #(.E(ELEMENT_BITS), .RW(RW)) u_front (
        .i_clk(i_clk), .i_ctl(n_ctl), .i_a(w_a), .o_num(w_num), .o_den(w_den),
        .o_neg(w_neg), .o_zero(w_zero), .o_det(w_det)
    );

    for (genvar i = 0; i < 9; i++) begin : g_div
        m3i_div #(.RW(RW)) u_div (
            .i_clk(i_clk), .i_ctl(n_ctl), .i_num(w_num[i]), .i_den(w_den),
            .i_neg(w_neg[i]), .i_zero(w_zero), .o_q(w_q[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (n_ctl.en) begin
            r_detd[0] <= w_zero ? '0 : w_det;
            r_sngd[0] <= w_zero;
            for (int k = 1; k < DD; k++) begin
                r_detd[k] <= r_detd[k-1];
                r_sngd[k] <= r_sngd[k-1];
            end
        end
    end

    assign o_valid       = r_vld[LAT-1];
    assign o_inv_00      = w_q[0];
    assign o_inv_01      = w_q[1];
    assign o_inv_02      = w_q[2];
    assign o_inv_10      = w_q[3];
    assign o_inv_11      = w_q[4];
    assign o_inv_12      = w_q[5];
    assign o_inv_20      = w_q[6];
    assign o_inv_21      = w_q[7];
    assign o_inv_22      = w_q[8];
    assign o_determinant = r_detd[DD-1];
    assign o_singular    = r_sngd[DD-1];

    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_singular |-> o_determinant == '0 && o_inv_00 == '0 && o_inv_22 == '0)
        else $error("singular item carries nonzero data");
    a_det_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_singular |-> o_determinant != '0)
        else $error("regular item with zero determinant");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_determinant) && $stable(o_inv_11))
        else $error("stalled result changed");
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no pending result");

endmodule
`default_nettype wire
